>>> src/wbkf_pkg.sv
package wbkf_pkg;

    // Request mode codes
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_SEARCH = 2'd2;

    // Response status codes
    localparam logic [2:0] STATUS_APPENDED  = 3'd0;
    localparam logic [2:0] STATUS_UPDATED   = 3'd1;
    localparam logic [2:0] STATUS_OVER_CAP  = 3'd2;
    localparam logic [2:0] STATUS_FULL      = 3'd3;
    localparam logic [2:0] STATUS_REMOVED   = 3'd4;
    localparam logic [2:0] STATUS_EMPTY     = 3'd5;
    localparam logic [2:0] STATUS_FOUND     = 3'd6;
    localparam logic [2:0] STATUS_NOT_FOUND = 3'd7;

    // One stored queue entry
    typedef struct packed {
        logic [15:0] code;
        logic [31:0] price;
        logic [15:0] weight;
    } t_entry;

    // Controller to datapath
    typedef struct packed {
        logic start;   // capture request, restart scan
        logic rd;      // read next entry of the scan
        logic commit;  // apply the operation and load the response
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] mode;
        logic       hit;       // last entry read carries the request code
        logic       more;      // entries left to read
        logic       out_free;  // response register can take a new response
    } t_dp_sts;

endpackage

>>> src/wbkf_if.sv
interface wbkf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] code;
    logic [31:0] price;
    logic [15:0] weight;

    modport source (output valid, output mode, output code, output price, output weight,
                    input ready);
    modport sink   (input valid, input mode, input code, input price, input weight,
                    output ready);
endinterface

interface wbkf_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] out_code;
    logic [31:0] out_price;
    logic [15:0] out_weight;
    logic [15:0] load;

    modport source (output valid, output status, output out_code, output out_price,
                    output out_weight, output load, input ready);
    modport sink   (input valid, input status, input out_code, input out_price,
                    input out_weight, input load, output ready);
endinterface

interface wbkf_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

>>> src/wbkf_ctrl.sv
module wbkf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    output wbkf_pkg::t_dp_cmd o_cmd,
    input  wbkf_pkg::t_dp_sts i_sts
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    // Take a request only when no operation is in flight
    assign o_req_ready = (r_state == ST_IDLE);

    // Sequence commands
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (i_sts.mode)
                    wbkf_pkg::MODE_INSERT, wbkf_pkg::MODE_SEARCH: begin
                        n_state = ST_SCAN;
                    end
                    wbkf_pkg::MODE_REMOVE: begin
                        // read the head when the queue holds anything
                        o_cmd.rd = i_sts.more;
                        n_state  = ST_FIN;
                    end
                    default: begin
                        n_state = ST_FIN;
                    end
                endcase
            end
            ST_SCAN: begin
                // stop on the first match, else read on until all entries are seen
                if (i_sts.hit) begin
                    n_state = ST_FIN;
                end else if (i_sts.more) begin
                    o_cmd.rd = 1'b1;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> src/wbkf_dp.sv
module wbkf_dp #(
    parameter int DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wbkf_pkg::t_dp_cmd i_cmd,
    output wbkf_pkg::t_dp_sts o_sts,
    // request payload
    input  logic [1:0]        i_mode,
    input  logic [15:0]       i_code,
    input  logic [31:0]       i_price,
    input  logic [15:0]       i_weight,
    // capacity register write
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_capacity,
    // response register
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output logic [2:0]        o_status,
    output logic [15:0]       o_out_code,
    output logic [31:0]       o_out_price,
    output logic [15:0]       o_out_weight,
    output logic [15:0]       o_load
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    // Entry store
    wbkf_pkg::t_entry mem [DEPTH];

    // Captured request
    logic [1:0]  r_mode;
    logic [15:0] r_code;
    logic [31:0] r_price;
    logic [15:0] r_weight;

    // Queue state
    logic [15:0]   r_cap;
    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [15:0]   r_load;

    // Scan state
    logic [CW-1:0]    r_idx;
    logic             r_pend;
    logic [AW-1:0]    r_rd_pos;
    wbkf_pkg::t_entry r_rdata;

    // Response register
    logic        r_rsp_valid;
    logic [2:0]  r_status;
    logic [15:0] r_oc;
    logic [31:0] r_op;
    logic [15:0] r_ow;
    logic [15:0] r_oload;

    logic [2:0]       n_status;
    logic [15:0]      n_oc;
    logic [31:0]      n_op;
    logic [15:0]      n_ow;
    logic [AW-1:0]    n_head;
    logic [CW-1:0]    n_count;
    logic [15:0]      n_load;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    wbkf_pkg::t_entry wr_data;

    logic [AW:0]   rd_sum;
    logic [AW-1:0] rd_addr;
    logic [AW:0]   tail_sum;
    logic [AW-1:0] tail_addr;
    logic [AW:0]   next_sum;
    logic [AW-1:0] next_head;
    logic          hit;
    logic [16:0]   upd_load;
    logic [16:0]   app_load;

    // Wrap head plus offset into the ring
    assign rd_sum    = {1'b0, r_head} + {1'b0, r_idx[AW-1:0]};
    assign rd_addr   = (rd_sum >= DEPTH_A) ? AW'(rd_sum - DEPTH_A) : rd_sum[AW-1:0];
    assign tail_sum  = {1'b0, r_head} + {1'b0, r_count[AW-1:0]};
    assign tail_addr = (tail_sum >= DEPTH_A) ? AW'(tail_sum - DEPTH_A) : tail_sum[AW-1:0];
    assign next_sum  = {1'b0, r_head} + (AW + 1)'(1);
    assign next_head = (next_sum >= DEPTH_A) ? AW'(next_sum - DEPTH_A) : next_sum[AW-1:0];

    assign hit      = r_pend && (r_rdata.code == r_code);
    assign upd_load = {1'b0, r_load} - {1'b0, r_rdata.weight} + {1'b0, r_weight};
    assign app_load = {1'b0, r_load} + {1'b0, r_weight};

    // Report to the controller
    assign o_sts.mode     = r_mode;
    assign o_sts.hit      = hit;
    assign o_sts.more     = (r_idx < r_count);
    assign o_sts.out_free = !r_rsp_valid || i_rsp_ready;

    // Work out the operation's outcome
    always_comb begin
        n_status = wbkf_pkg::STATUS_NOT_FOUND;
        n_oc     = '0;
        n_op     = '0;
        n_ow     = '0;
        n_head   = r_head;
        n_count  = r_count;
        n_load   = r_load;
        wr_en    = 1'b0;
        wr_addr  = r_rd_pos;
        wr_data  = '{code: r_code, price: r_price, weight: r_weight};
        case (r_mode)
            wbkf_pkg::MODE_INSERT: begin
                if (hit) begin
                    // update in place when the new load fits
                    if (upd_load > {1'b0, r_cap}) begin
                        n_status = wbkf_pkg::STATUS_OVER_CAP;
                    end else begin
                        n_status = wbkf_pkg::STATUS_UPDATED;
                        n_load   = upd_load[15:0];
                        wr_en    = 1'b1;
                    end
                end else if (app_load > {1'b0, r_cap}) begin
                    n_status = wbkf_pkg::STATUS_OVER_CAP;
                end else if (r_count == DEPTH_C) begin
                    n_status = wbkf_pkg::STATUS_FULL;
                end else begin
                    n_status = wbkf_pkg::STATUS_APPENDED;
                    n_load   = app_load[15:0];
                    n_count  = r_count + CW'(1);
                    wr_en    = 1'b1;
                    wr_addr  = tail_addr;
                end
            end
            wbkf_pkg::MODE_REMOVE: begin
                if (r_count == '0) begin
                    n_status = wbkf_pkg::STATUS_EMPTY;
                end else begin
                    n_status = wbkf_pkg::STATUS_REMOVED;
                    n_oc     = r_rdata.code;
                    n_op     = r_rdata.price;
                    n_ow     = r_rdata.weight;
                    n_load   = (r_load >= r_rdata.weight) ? r_load - r_rdata.weight : '0;
                    n_head   = next_head;
                    n_count  = r_count - CW'(1);
                end
            end
            wbkf_pkg::MODE_SEARCH: begin
                if (hit) begin
                    n_status = wbkf_pkg::STATUS_FOUND;
                    n_oc     = r_rdata.code;
                    n_op     = r_rdata.price;
                    n_ow     = r_rdata.weight;
                end
            end
            default: begin
                n_status = wbkf_pkg::STATUS_NOT_FOUND;
            end
        endcase
    end

    // Write and read the entry store
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // Capture the request and the read position
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mode   <= i_mode;
            r_code   <= i_code;
            r_price  <= i_price;
            r_weight <= i_weight;
        end
        if (i_cmd.rd) begin
            r_rd_pos <= rd_addr;
        end
    end

    // Advance the scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_pend <= 1'b0;
        end else if (i_cmd.start) begin
            r_idx  <= '0;
            r_pend <= 1'b0;
        end else if (i_cmd.rd) begin
            r_idx  <= r_idx + CW'(1);
            r_pend <= 1'b1;
        end
    end

    // Hold queue state and capacity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= '0;
            r_head  <= '0;
            r_count <= '0;
            r_load  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_capacity;
            end
            if (i_cmd.commit) begin
                r_head  <= n_head;
                r_count <= n_count;
                r_load  <= n_load;
            end
        end
    end

    // Load and drop the response
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status <= n_status;
            r_oc     <= n_oc;
            r_op     <= n_op;
            r_ow     <= n_ow;
            r_oload  <= n_load;
        end
    end

    assign o_rsp_valid  = r_rsp_valid;
    assign o_status     = r_status;
    assign o_out_code   = r_oc;
    assign o_out_price  = r_op;
    assign o_out_weight = r_ow;
    assign o_load       = r_oload;

endmodule

>>> src/weight_budget_keyed_fifo_unit.sv
// Keyed FIFO of up to DEPTH entries (code, price, weight); an insert that would take the
// total weight over the capacity register is refused. Requests are handled one at a time.
// Insert and search walk the queue from head to tail through the single read port of the
// entry store, one entry per cycle, and stop at the first matching code. Remove reads
// only the head. A response waits in an output register, and the next request is taken
// while it waits; the response register must be free before the following operation can
// finish. The capacity port is always ready and should be written only while no request
// is in flight.
module weight_budget_keyed_fifo_unit #(
    parameter int DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    wbkf_in_if.sink           i_req,
    wbkf_out_if.source        o_rsp,
    wbkf_cfg_if.sink          i_cfg
);

    wbkf_pkg::t_dp_cmd cmd;
    wbkf_pkg::t_dp_sts sts;
    logic              req_ready;

    assign i_req.ready = req_ready;
    assign i_cfg.ready = 1'b1;

    // Sequence each request
    wbkf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // Store entries, scan and apply
    wbkf_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_mode         (i_req.mode),
        .i_code         (i_req.code),
        .i_price        (i_req.price),
        .i_weight       (i_req.weight),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_capacity (i_cfg.capacity),
        .o_rsp_valid    (o_rsp.valid),
        .i_rsp_ready    (o_rsp.ready),
        .o_status       (o_rsp.status),
        .o_out_code     (o_rsp.out_code),
        .o_out_price    (o_rsp.out_price),
        .o_out_weight   (o_rsp.out_weight),
        .o_load         (o_rsp.load)
    );

endmodule

>>> tb/sv/weight_budget_keyed_fifo_unit_test.sv
`timescale 1ns / 100ps

module weight_budget_keyed_fifo_unit_test;

    localparam int DEPTH = 16;
    localparam int SLOT_BITS = $clog2(DEPTH);
    localparam int DRAIN_CYCLES = DEPTH + 8;
    localparam int RSP_HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 240;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] code;
        logic [31:0] price;
        logic [15:0] weight;
        logic [15:0] load;
    } t_rsp;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    wbkf_in_if  req_if ();
    wbkf_out_if rsp_if ();
    wbkf_cfg_if cfg_if ();

    weight_budget_keyed_fifo_unit #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_if.sink),
        .o_rsp  (rsp_if.source),
        .i_cfg  (cfg_if.sink)
    );

    // Shadow copy of the queue contents and budget
    wbkf_pkg::t_entry q_slot [DEPTH];
    int unsigned q_head = 0;
    int unsigned q_count = 0;
    int unsigned q_load = 0;
    int unsigned q_capacity = 0;

    t_rsp pending_rsp [$];
    int   error_count = 0;
    int   idle_pct = 0;
    int   stall_pct = 0;
    int   rsp_hold_req = 0;
    int   rsp_hold_ack = 0;
    int   rsp_hold_left = 0;

    always #4 clk = ~clk;

    // Abort a hung run
    initial begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Return the slot of the first entry from head to tail with this code, or -1
    function automatic int find_slot(input logic [15:0] code);
        int unsigned pos;
        for (int unsigned i = 0; i < q_count; i++) begin
            pos = (q_head + i) % DEPTH;
            if (q_slot[SLOT_BITS'(pos)].code == code) return int'(pos);
        end
        return -1;
    endfunction

    // Apply one request to the shadow queue and return the response it yields
    function automatic t_rsp predict_response(input logic [1:0] mode, input logic [15:0] code,
                                              input logic [31:0] price,
                                              input logic [15:0] weight);
        t_rsp        r;
        int          slot;
        int unsigned new_load;
        r = '0;
        r.status = wbkf_pkg::STATUS_NOT_FOUND;
        case (mode)
            wbkf_pkg::MODE_INSERT: begin
                slot = find_slot(code);
                if (slot >= 0) begin
                    new_load = q_load - 32'(q_slot[SLOT_BITS'(slot)].weight) + 32'(weight);
                    if (new_load > q_capacity) begin
                        r.status = wbkf_pkg::STATUS_OVER_CAP;
                    end else begin
                        q_load = new_load;
                        q_slot[SLOT_BITS'(slot)].price = price;
                        q_slot[SLOT_BITS'(slot)].weight = weight;
                        r.status = wbkf_pkg::STATUS_UPDATED;
                    end
                end else if (q_load + 32'(weight) > q_capacity) begin
                    r.status = wbkf_pkg::STATUS_OVER_CAP;
                end else if (q_count >= DEPTH) begin
                    r.status = wbkf_pkg::STATUS_FULL;
                end else begin
                    q_slot[SLOT_BITS'((q_head + q_count) % DEPTH)] = {code, price, weight};
                    q_count++;
                    q_load += 32'(weight);
                    r.status = wbkf_pkg::STATUS_APPENDED;
                end
            end
            wbkf_pkg::MODE_REMOVE: begin
                if (q_count == 0) begin
                    r.status = wbkf_pkg::STATUS_EMPTY;
                end else begin
                    r.code = q_slot[SLOT_BITS'(q_head)].code;
                    r.price = q_slot[SLOT_BITS'(q_head)].price;
                    r.weight = q_slot[SLOT_BITS'(q_head)].weight;
                    q_load = (q_load >= 32'(r.weight)) ? q_load - 32'(r.weight) : 0;
                    q_head = (q_head + 1) % DEPTH;
                    q_count--;
                    r.status = wbkf_pkg::STATUS_REMOVED;
                end
            end
            wbkf_pkg::MODE_SEARCH: begin
                slot = find_slot(code);
                if (slot >= 0) begin
                    r.code = q_slot[SLOT_BITS'(slot)].code;
                    r.price = q_slot[SLOT_BITS'(slot)].price;
                    r.weight = q_slot[SLOT_BITS'(slot)].weight;
                    r.status = wbkf_pkg::STATUS_FOUND;
                end
            end
            default: begin
            end
        endcase
        r.load = q_load[15:0];
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] exp_val,
                                          input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_val, act_val);
            error_count++;
        end
    endfunction

    // Count down a long hold of the response side when one is asked for
    initial begin
        forever begin
            @(posedge clk);
            if (rsp_hold_req != rsp_hold_ack) begin
                rsp_hold_left = RSP_HOLD_CYCLES;
                rsp_hold_ack = rsp_hold_req;
            end else if (rsp_hold_left != 0) begin
                rsp_hold_left--;
            end
        end
    end

    // Check each accepted response against the oldest prediction and drive ready
    initial begin
        t_rsp exp_rsp;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rsp_if.valid && rsp_if.ready) begin
                if (pending_rsp.size() == 0) begin
                    $display("%0t: response with none expected, status %0d load %0d",
                             $time, rsp_if.status, rsp_if.load);
                    error_count++;
                end else begin
                    exp_rsp = pending_rsp.pop_front();
                    compare_field("status", 32'(exp_rsp.status), 32'(rsp_if.status));
                    compare_field("out_code", 32'(exp_rsp.code), 32'(rsp_if.out_code));
                    compare_field("out_price", exp_rsp.price, rsp_if.out_price);
                    compare_field("out_weight", 32'(exp_rsp.weight), 32'(rsp_if.out_weight));
                    compare_field("load", 32'(exp_rsp.load), 32'(rsp_if.load));
                end
            end
            // Hold off the response side while a long hold runs
            if (rsp_hold_left != 0) begin
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Offer one request after a random gap and record its expected response
    task automatic send_request(input logic [1:0] mode, input logic [15:0] code,
                                input logic [31:0] price, input logic [15:0] weight);
        while ($urandom_range(99) < idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.mode <= mode;
        req_if.code <= code;
        req_if.price <= price;
        req_if.weight <= weight;
        do @(posedge clk); while (!req_if.ready);
        pending_rsp.push_back(predict_response(mode, code, price, weight));
    endtask

    // Mostly a small key pool so updates and search hits happen; some full-range noise
    task automatic send_random(input int weight_max);
        int          pick;
        logic [1:0]  mode;
        logic [15:0] code;
        logic [15:0] weight;
        pick = $urandom_range(99);
        if (pick < 45) mode = wbkf_pkg::MODE_INSERT;
        else if (pick < 70) mode = wbkf_pkg::MODE_REMOVE;
        else if (pick < 95) mode = wbkf_pkg::MODE_SEARCH;
        else mode = MODE_UNUSED;
        if ($urandom_range(99) < 10) begin
            code = 16'($urandom);
            weight = 16'($urandom);
        end else begin
            code = 16'($urandom_range(23));
            weight = 16'($urandom_range(weight_max));
        end
        send_request(mode, code, $urandom, weight);
    endtask

    // Drop valid and wait until every response is back and the block has settled
    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [15:0] value);
        wait_idle();
        cfg_if.valid <= 1'b1;
        cfg_if.capacity <= value;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        q_capacity = 32'(value);
    endtask

    task automatic run_phase(input int idle, input int stall, input logic [15:0] cap);
        set_capacity(cap);
        idle_pct = idle;
        stall_pct = stall;
        repeat (PHASE_ITEMS) send_random(int'(cap) / 12 + 1);
    endtask

    // Empty queue, unused mode, and a zero budget
    task automatic test_empty_queue();
        set_capacity(16'd0);
        send_request(wbkf_pkg::MODE_REMOVE, 16'd0, 32'd0, 16'd0);
        send_request(wbkf_pkg::MODE_SEARCH, 16'd9, 32'd0, 16'd0);
        send_request(MODE_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(wbkf_pkg::MODE_INSERT, 16'hFFFF, 32'h1234_5678, 16'hFFFF);
        send_request(wbkf_pkg::MODE_INSERT, 16'd0, 32'd0, 16'd0);
    endtask

    // Fill every slot, then refuse on budget before refusing on space
    task automatic test_fill_and_full();
        set_capacity(16'hFFFF);
        send_request(wbkf_pkg::MODE_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 16'd30000);
        for (int i = 1; i < DEPTH; i++) begin
            send_request(wbkf_pkg::MODE_INSERT, 16'(i), 32'(i), 16'd2000);
        end
        send_request(wbkf_pkg::MODE_INSERT, 16'd101, 32'd1, 16'd6000);
        send_request(wbkf_pkg::MODE_INSERT, 16'd100, 32'd2, 16'd0);
        send_request(wbkf_pkg::MODE_INSERT, 16'd5, 32'hA5A5_5A5A, 16'd7000);
        send_request(wbkf_pkg::MODE_INSERT, 16'd5, 32'd3, 16'd10000);
        send_request(wbkf_pkg::MODE_SEARCH, 16'hFFFF, 32'd0, 16'd0);
        send_request(wbkf_pkg::MODE_SEARCH, 16'd200, 32'd0, 16'd0);
    endtask

    // Budget lowered under the held load: entries stay, inserts are refused
    task automatic test_lowered_capacity();
        set_capacity(16'd1000);
        send_request(wbkf_pkg::MODE_INSERT, 16'd3, 32'd4, 16'd0);
        send_request(wbkf_pkg::MODE_REMOVE, 16'd0, 32'd0, 16'd0);
        send_request(wbkf_pkg::MODE_REMOVE, 16'd0, 32'd0, 16'd0);
    endtask

    task automatic test_random_phases();
        run_phase(0, 0, 16'hFFFF);
        run_phase(73, 0, 16'($urandom_range(2000, 65535)));
        run_phase(0, 73, 16'd500);
        run_phase(19, 19, 16'($urandom));
    endtask

    // Stall the response side while requests keep coming so the input backs up
    task automatic test_backpressure();
        set_capacity(16'd40000);
        idle_pct = 0;
        stall_pct = 0;
        rsp_hold_req++;
        repeat (40) send_random(4000);
    endtask

    initial begin
        req_if.valid <= 1'b0;
        req_if.mode <= wbkf_pkg::MODE_INSERT;
        req_if.code <= '0;
        req_if.price <= '0;
        req_if.weight <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.capacity <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_queue();
        test_fill_and_full();
        test_lowered_capacity();
        test_random_phases();
        test_backpressure();

        wait_idle();
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
src/wbkf_pkg.sv
src/wbkf_if.sv
src/wbkf_ctrl.sv
src/wbkf_dp.sv
src/weight_budget_keyed_fifo_unit.sv
tb/sv/weight_budget_keyed_fifo_unit_test.sv
